>>> rtl/mrd_pkg.sv
package mrd_pkg;

   // command codes; code three behaves as a post at front
   localparam logic [1:0] CMD_GET   = 2'd0;
   localparam logic [1:0] CMD_BACK  = 2'd1;
   localparam logic [1:0] CMD_FRONT = 2'd2;
   localparam logic [1:0] CMD_ALT   = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int          CAP_BITS  = 5;
   localparam logic [4:0]  CAP_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] msg_in;
      logic        waiter_present;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] msg_out;
      logic        handed_over;
      logic [4:0]  level;
   } rsp_type;

endpackage

>>> rtl/mailbox_ring_deque_core.sv
// Channel  Ports              Direction  Carries
// req      req_valid/ready    in         mrd_pkg::req_type (cmd, msg_in, waiter_present)
// rsp      rsp_valid/ready    out        mrd_pkg::rsp_type (status, msg_out, handed_over, level)
// csr      csr_valid/ready    in         capacity, 5 bits (always ready)
//
// One request per cycle while no result is stalled; each result appears in the cycle after its request transfer.
// The registered read of the message store, taken at accept, sets this timing.
// Reset (synchronous, high) clears pointers, count and result valid; capacity returns to 16.
// The message store is not cleared; a slot never written reads as anything.
// A stalled result blocks new requests only while rsp_ready is low.
module mailbox_ring_deque_core #(
   parameter int SLOTS    = 16,
   parameter int MSG_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mrd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mrd_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [4:0]        csr_data
);

   localparam int PW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   // wide enough for the count, the clamped capacity and a raw capacity code
   localparam int WW = ((CW > mrd_pkg::CAP_BITS) ? CW : mrd_pkg::CAP_BITS) + 1;

   // configuration
   logic [4:0]    capacity_ff;
   logic [WW-1:0] cap_eff;

   // ring state
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;
   logic          handed_ff, handed_in;
   logic [4:0]    level_ff, level_in;
   logic [31:0]   pass_msg_ff, pass_msg_in;
   logic          use_rd_ff, use_rd_in;

   // store access
   logic                wr_en, rd_en;
   logic [PW-1:0]       wr_addr;
   logic [MSG_BITS-1:0] wr_data, rd_data;

   logic          req_xfer;
   logic [63:0]   msg_wide, msg_masked, rd_wide;
   logic [WW-1:0] head_nx, tail_nx, count_w;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= mrd_pkg::CAP_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_data;
      end
   end

   // clamp capacity to 1..SLOTS
   always_comb begin
      cap_eff = WW'(capacity_ff);
      if (capacity_ff == '0) begin
         cap_eff = WW'(1);
      end else if (WW'(capacity_ff) > WW'(SLOTS)) begin
         cap_eff = WW'(SLOTS);
      end
   end

   // message kept at MSG_BITS bits
   always_comb begin
      msg_wide   = {32'd0, req_data.msg_in};
      msg_masked = '0;
      msg_masked[MSG_BITS-1:0] = msg_wide[MSG_BITS-1:0];
      rd_wide    = '0;
      rd_wide[MSG_BITS-1:0] = rd_data;
   end

   assign wr_data = msg_wide[MSG_BITS-1:0];
   assign head_nx = WW'(head_ff) + WW'(1);
   assign tail_nx = WW'(tail_ff) + WW'(1);
   assign count_w = WW'(count_ff);

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_ff;
      rd_en        = 1'b0;
      status_in    = mrd_pkg::ST_OK;
      handed_in    = 1'b0;
      pass_msg_in  = '0;
      use_rd_in    = 1'b0;
      if (req_xfer) begin
         if (req_data.cmd == mrd_pkg::CMD_GET) begin
            // waiter flag has no bearing on a get
            if (count_ff != '0) begin
               rd_en     = 1'b1;
               use_rd_in = 1'b1;
               count_in  = count_ff - CW'(1);
               head_in   = (head_nx >= cap_eff) ? '0 : head_nx[PW-1:0];
            end else begin
               status_in = mrd_pkg::ST_EMPTY;
            end
         end else if (req_data.waiter_present) begin
            // straight handover, even when full
            handed_in   = 1'b1;
            pass_msg_in = msg_masked[31:0];
         end else if (count_w >= cap_eff) begin
            status_in = mrd_pkg::ST_FULL;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            case (req_data.cmd) inside
               mrd_pkg::CMD_BACK: begin
                  wr_addr = tail_ff;
                  tail_in = (tail_nx >= cap_eff) ? '0 : tail_nx[PW-1:0];
               end
               mrd_pkg::CMD_FRONT, mrd_pkg::CMD_ALT: begin
                  head_in = (head_ff == '0) ? PW'(cap_eff - WW'(1)) : head_ff - PW'(1);
                  wr_addr = head_in;
               end
               default: begin
                  wr_addr = tail_ff;
               end
            endcase
         end
      end
   end

   always_comb begin
      logic [WW-1:0] lvl_w;
      lvl_w    = WW'(count_in);
      level_in = lvl_w[4:0];
   end

   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload loads only on a request transfer, so it holds while stalled
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         status_ff   <= status_in;
         handed_ff   <= handed_in;
         level_ff    <= level_in;
         pass_msg_ff <= pass_msg_in;
         use_rd_ff   <= use_rd_in;
      end
   end

   mrd_store #(
      .DEPTH (SLOTS),
      .WIDTH (MSG_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data.status      = status_ff;
   assign rsp_data.msg_out     = use_rd_ff ? rd_wide[31:0] : pass_msg_ff;
   assign rsp_data.handed_over = handed_ff;
   assign rsp_data.level       = level_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(SLOTS) >= count_ff)
      else $error("held count beyond store depth");

   a_handover_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && handed_ff |-> status_ff == mrd_pkg::ST_OK && !use_rd_ff)
      else $error("handover with bad status or store read");

   a_empty_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == mrd_pkg::ST_EMPTY |-> level_ff == '0)
      else $error("empty result with nonzero level");

   a_handover_keeps: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_data.cmd != mrd_pkg::CMD_GET && req_data.waiter_present
      |=> $stable(count_ff) && $stable(head_ff) && $stable(tail_ff))
      else $error("handover disturbed ring state");

   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && !rsp_ready)
      else $error("request stalled without a waiting result");
`endif

endmodule

>>> rtl/mrd_store.sv
module mrd_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> bench/mailbox_ring_deque_core_tb.sv
module mailbox_ring_deque_core_tb;

   localparam int SLOT_COUNT  = 16;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 220;
   localparam int DIR_ROWS    = 25;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_STALL  = 300;

   // one row of the directed table: the request, and the result where it is
   // obvious enough to type in (otherwise the mailbox predictor supplies it)
   typedef struct packed {
      mrd_pkg::req_type item;
      logic             typed;
      mrd_pkg::rsp_type due;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   mrd_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   mrd_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [4:0] csr_data = 5'd0;

   mailbox_ring_deque_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Mailbox predictor: own copy of the capacity register, the ring and its
   // pointers. slot_written tracks which slots hold a real message, so that
   // the stimulus never pops a slot whose contents are undefined.
   // ---------------------------------------------------------------------
   logic [4:0]  cap_reg = mrd_pkg::CAP_RESET;
   logic [31:0] slot_word [SLOT_COUNT];
   bit          slot_written [SLOT_COUNT];
   logic [3:0]  head_ptr = 4'd0;
   logic [3:0]  tail_ptr = 4'd0;
   logic [4:0]  held = 5'd0;

   // what came through, for the closing summary
   int n_reqs = 0, n_pops = 0, n_stored = 0, n_full = 0, n_empty = 0, n_handed = 0;
   int n_cap_writes = 0;

   mrd_pkg::rsp_type due_rsp [$];   // expected results, oldest first
   int      errors = 0;

   // idle percentages of sender and receiver; changed per phase
   int tx_idle_pct = 25;
   int rx_idle_pct = 60;
   // long receiver stalls asked for by the stimulus, and those already served
   int stall_asks = 0;
   int stalls_served = 0;

   dir_row_type dir_table [DIR_ROWS];

   function automatic logic [3:0] step_on(input logic [3:0] p, input int cap);
      return (int'(p) + 1 >= cap) ? 4'd0 : p + 4'd1;
   endfunction

   function automatic mrd_pkg::rsp_type mailbox_apply(input mrd_pkg::req_type r);
      mrd_pkg::rsp_type res;
      int      cap;
      res = '0;
      res.status = mrd_pkg::ST_OK;
      // out-of-range register values clamp to the usable span
      cap = (cap_reg == 5'd0) ? 1 : ((int'(cap_reg) > SLOT_COUNT) ? SLOT_COUNT : int'(cap_reg));
      if (r.cmd == mrd_pkg::CMD_GET) begin
         // waiter flag plays no part in a get
         if (held != 5'd0) begin
            held = held - 5'd1;
            res.msg_out = slot_word[head_ptr];
            head_ptr = step_on(head_ptr, cap);
            n_pops++;
         end else begin
            res.status = mrd_pkg::ST_EMPTY;
            n_empty++;
         end
      end else if (r.waiter_present) begin
         // handover bypasses the ring, even when it is full
         res.msg_out = r.msg_in;
         res.handed_over = 1'b1;
         n_handed++;
      end else if (int'(held) >= cap) begin
         res.status = mrd_pkg::ST_FULL;
         n_full++;
      end else begin
         if (r.cmd == mrd_pkg::CMD_BACK) begin
            slot_word[tail_ptr] = r.msg_in;
            slot_written[tail_ptr] = 1'b1;
            tail_ptr = step_on(tail_ptr, cap);
         end else begin
            // front post, and the alternative code which behaves the same
            head_ptr = (head_ptr == 4'd0) ? 4'(cap - 1) : head_ptr - 4'd1;
            slot_word[head_ptr] = r.msg_in;
            slot_written[head_ptr] = 1'b1;
         end
         held = held + 5'd1;
         n_stored++;
      end
      res.level = held;
      return res;
   endfunction

   function automatic dir_row_type mk_row(input logic [1:0] c, input logic [31:0] m,
                                          input logic w, input logic t,
                                          input logic [1:0] st, input logic [31:0] mo,
                                          input logic ho, input logic [4:0] lv);
      dir_row_type row;
      row.item.cmd = c;
      row.item.msg_in = m;
      row.item.waiter_present = w;
      row.typed = t;
      row.due.status = st;
      row.due.msg_out = mo;
      row.due.handed_over = ho;
      row.due.level = lv;
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Valid goes high with the payload and stays until the
   // transfer; the expectation is booked at the transfer edge.
   // ---------------------------------------------------------------------
   task automatic send_req(input mrd_pkg::req_type item, input logic typed,
                           input mrd_pkg::rsp_type due);
      mrd_pkg::rsp_type pred;
      // random gap before offering, valid low throughout
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      pred = mailbox_apply(item);
      due_rsp.push_back(typed ? due : pred);
      n_reqs++;
   endtask

   // wait until every booked result has been collected, then idle on past the
   // registered result stage
   task automatic drain_results;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // capacity write; only ever issued with the block idle
   task automatic write_capacity(input logic [4:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cap_reg = value;
      n_cap_writes++;
   endtask

   // ---------------------------------------------------------------------
   // Result side: random back-pressure plus the occasional long stall,
   // counted here so that the sender keeps pushing while it lasts.
   // ---------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_asks != stalls_served) begin
            stalls_served = stall_asks;
            stall_left = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   // every result transfer is matched against the oldest expectation
   always @(posedge clock) begin : result_check
      mrd_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_rsp.size() == 0) begin
            errors++;
            $display("%0t: result with none expected, expected nothing, got %p", $time, rsp_data);
         end else begin
            want = due_rsp.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("msg_out", want.msg_out, rsp_data.msg_out);
            check_field("handed_over", 32'(want.handed_over), 32'(rsp_data.handed_over));
            check_field("level", 32'(want.level), 32'(rsp_data.level));
         end
      end
   end

   // watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycles, due_rsp.size());
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      mrd_pkg::req_type item;
      logic [4:0] cap_plan [PHASES];
      int         get_pct;
      int         pick;

      // directed part, at the reset capacity of 16 with an empty ring:
      // empty gets, handovers, fill to the brim with back and front posts,
      // full posts, handover on a full ring, then pops
      dir_table = '{
         mk_row(mrd_pkg::CMD_GET,   32'h0000_0000, 1'b0,
                1'b1, mrd_pkg::ST_EMPTY, 32'h0000_0000, 1'b0, 5'd0),
         mk_row(mrd_pkg::CMD_BACK,  32'hFFFF_FFFF, 1'b1,
                1'b1, mrd_pkg::ST_OK,    32'hFFFF_FFFF, 1'b1, 5'd0),
         mk_row(mrd_pkg::CMD_GET,   32'hDEAD_BEEF, 1'b1,
                1'b1, mrd_pkg::ST_EMPTY, 32'h0000_0000, 1'b0, 5'd0),
         mk_row(mrd_pkg::CMD_FRONT, 32'h0000_0000, 1'b1,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b1, 5'd0),
         mk_row(mrd_pkg::CMD_BACK,  32'h0000_0000, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd1),
         mk_row(mrd_pkg::CMD_BACK,  32'hFFFF_FFFF, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd2),
         mk_row(mrd_pkg::CMD_BACK,  32'h8000_0000, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd3),
         mk_row(mrd_pkg::CMD_BACK,  32'h0000_0001, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd4),
         mk_row(mrd_pkg::CMD_BACK,  32'hAAAA_AAAA, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd5),
         mk_row(mrd_pkg::CMD_BACK,  32'h5555_5555, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd6),
         mk_row(mrd_pkg::CMD_BACK,  32'h7FFF_FFFF, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd7),
         mk_row(mrd_pkg::CMD_BACK,  32'hFFFF_FFFE, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd8),
         mk_row(mrd_pkg::CMD_FRONT, 32'h0123_4567, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd9),
         mk_row(mrd_pkg::CMD_FRONT, 32'h89AB_CDEF, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd10),
         mk_row(mrd_pkg::CMD_FRONT, 32'h0F0F_0F0F, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd11),
         mk_row(mrd_pkg::CMD_FRONT, 32'hF0F0_F0F0, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd12),
         mk_row(mrd_pkg::CMD_FRONT, 32'h3333_CCCC, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd13),
         mk_row(mrd_pkg::CMD_FRONT, 32'hCCCC_3333, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd14),
         mk_row(mrd_pkg::CMD_FRONT, 32'h0000_FFFF, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd15),
         mk_row(mrd_pkg::CMD_ALT,   32'hFFFF_0000, 1'b0,
                1'b1, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd16),
         mk_row(mrd_pkg::CMD_BACK,  32'h1111_1111, 1'b0,
                1'b1, mrd_pkg::ST_FULL,  32'h0000_0000, 1'b0, 5'd16),
         mk_row(mrd_pkg::CMD_FRONT, 32'h2222_2222, 1'b0,
                1'b1, mrd_pkg::ST_FULL,  32'h0000_0000, 1'b0, 5'd16),
         mk_row(mrd_pkg::CMD_ALT,   32'h1234_5678, 1'b1,
                1'b1, mrd_pkg::ST_OK,    32'h1234_5678, 1'b1, 5'd16),
         mk_row(mrd_pkg::CMD_GET,   32'h0000_0000, 1'b0,
                1'b0, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd0),
         mk_row(mrd_pkg::CMD_GET,   32'hFFFF_FFFF, 1'b1,
                1'b0, mrd_pkg::ST_OK,    32'h0000_0000, 1'b0, 5'd0)
      };

      // capacity per phase: smallest, zero (acts as one), beyond the slot
      // count (acts as sixteen), and a spread in between; messages stay held
      // across the changes, so pointers past the wrap point get exercised
      cap_plan = '{5'd1, 5'd0, 5'd4, 5'd31, 5'd17, 5'd2, 5'd16, 5'd9, 5'd3};

      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_word[i] = '0;
         slot_written[i] = 1'b0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++)
         send_req(dir_table[i].item, dir_table[i].typed, dir_table[i].due);
      req_valid <= 1'b0;
      drain_results;

      for (int phase = 0; phase < PHASES; phase++) begin
         // receiver lazy first, then sender lazy, then both flat out
         if (phase < 3) begin
            tx_idle_pct = 25;
            rx_idle_pct = 60;
         end else if (phase < 6) begin
            tx_idle_pct = 60;
            rx_idle_pct = 25;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         // lean towards filling, draining or a balance in turn
         case (phase % 3)
            0: get_pct = 20;
            1: get_pct = 70;
            default: get_pct = 45;
         endcase

         write_capacity(cap_plan[phase]);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver stall while requests keep coming: the result
            // register fills and the request side has to back off
            if ((phase == 1 || phase == 7) && n == 40)
               stall_asks++;
            // sender stops until every outstanding result is back
            if (phase == 4 && n == 110) begin
               req_valid <= 1'b0;
               drain_results;
            end

            if ($urandom_range(99) < get_pct) begin
               item.cmd = mrd_pkg::CMD_GET;
            end else begin
               pick = $urandom_range(9);
               item.cmd = (pick < 5) ? mrd_pkg::CMD_BACK :
                          ((pick < 9) ? mrd_pkg::CMD_FRONT : mrd_pkg::CMD_ALT);
            end
            case ($urandom_range(7))
               0: item.msg_in = 32'h0000_0000;
               1: item.msg_in = 32'hFFFF_FFFF;
               default: item.msg_in = $urandom;
            endcase
            item.waiter_present = ($urandom_range(99) < 15);
            // never pop a slot that holds no message yet; post instead
            if (item.cmd == mrd_pkg::CMD_GET && held != 5'd0 && !slot_written[head_ptr]) begin
               item.cmd = mrd_pkg::CMD_BACK;
               item.waiter_present = 1'b0;
            end
            send_req(item, 1'b0, '0);
         end
         req_valid <= 1'b0;
         drain_results;
      end

      $display("%0d requests over %0d capacity settings: %0d pops, %0d stored,",
               n_reqs, n_cap_writes, n_pops, n_stored);
      $display("%0d full, %0d empty, %0d handovers, %0d long result stalls",
               n_full, n_empty, n_handed, stalls_served);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/mrd_pkg.sv
rtl/mrd_store.sv
rtl/mailbox_ring_deque_core.sv
bench/mailbox_ring_deque_core_tb.sv
